FILE: design/swm_pkg.sv
// Shared constants, state codes and control struct for the sliding window maximum block.
// Depends on nothing; used by swm_ctrl, swm_cell, sliding_window_maximum and the bench.
package swm_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned MAX_WINDOW_DEF  = 16;
  localparam int unsigned CFG_BITS        = 5;

  localparam logic [CFG_BITS-1:0] WIN_SIZE_RESET = 5'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  // per-cycle strobes from the controller to the datapath
  typedef struct packed {
    logic shift;    // word accepted: shift the sample row
    logic capture;  // max wave has reached the window end: load result register
  } swm_ctrl_t;

endpackage

FILE: design/swm_cell.sv
// One window cell: holds a sample and forwards a running maximum to its neighbor.
// Depends on swm_pkg for the default sample width.
module swm_cell #(
  parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          shift,
  input  logic signed [SAMPLE_BITS-1:0] s_in,
  input  logic signed [SAMPLE_BITS-1:0] pm_in,
  output logic signed [SAMPLE_BITS-1:0] s_out,
  output logic signed [SAMPLE_BITS-1:0] pm_out
);

  logic signed [SAMPLE_BITS-1:0] s_r;
  logic signed [SAMPLE_BITS-1:0] pm_r;
  logic signed [SAMPLE_BITS-1:0] pm_nxt;

  assign pm_nxt = (s_r > pm_in) ? s_r : pm_in;

  always_ff @(posedge clk) begin
    if (shift) begin
      s_r <= s_in;
    end
    pm_r <= pm_nxt;
  end

  assign s_out  = s_r;
  assign pm_out = pm_r;

endmodule

FILE: design/swm_ctrl.sv
// Controller: window size register, fill count, sweep counter and the state machine.
// Depends on swm_pkg for state codes, the control struct and config constants.
module swm_ctrl #(
  parameter int unsigned MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_window_size,
  input  logic                          in_valid,
  input  logic                          in_last_sample,
  input  logic                          out_free,
  output logic                          in_stall,
  output logic [IW-1:0]                 sel_idx,
  output swm_pkg::swm_ctrl_t            ctrl
);

  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CW = (FW > swm_pkg::CFG_BITS) ? FW : swm_pkg::CFG_BITS;
  localparam logic [CW-1:0] MAX_W = CW'(MAX_WINDOW);

  swm_pkg::state_t state_r, state_nxt;
  logic [swm_pkg::CFG_BITS-1:0] win_size_r;
  logic [CW-1:0] fill_r, fill_nxt, fill_inc;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ws_ext, eff_w;
  logic          accept, full, done;

  assign ws_ext = CW'(win_size_r);

  always_comb begin
    if (ws_ext == '0) begin
      eff_w = CW'(1);
    end else if (ws_ext > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = ws_ext;
    end
  end

  assign sel_idx  = IW'(eff_w - CW'(1));
  assign in_stall = (state_r != swm_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fill_inc = (fill_r < MAX_W) ? fill_r + CW'(1) : fill_r;
  assign full     = (fill_inc >= eff_w);
  assign done     = (cnt_r == eff_w) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swm_pkg::ST_IDLE: begin
        if (accept && full) begin
          state_nxt = swm_pkg::ST_SWEEP;
        end
      end
      swm_pkg::ST_SWEEP: begin
        if (done) begin
          state_nxt = swm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swm_pkg::ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    ctrl.shift   = 1'b0;
    ctrl.capture = 1'b0;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    unique case (state_r)
      swm_pkg::ST_IDLE: begin
        ctrl.shift = accept;
        cnt_nxt    = '0;
        if (accept) begin
          fill_nxt = in_last_sample ? '0 : fill_inc;
        end
      end
      swm_pkg::ST_SWEEP: begin
        ctrl.capture = done;
        if (cnt_r != eff_w) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= swm_pkg::ST_IDLE;
      fill_r     <= '0;
      cnt_r      <= '0;
      win_size_r <= swm_pkg::WIN_SIZE_RESET;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid) begin
        win_size_r <= cfg_window_size;
      end
    end
  end

endmodule

FILE: design/sliding_window_maximum.sv
// Top level of the sliding window maximum: cell row, controller and result register.
// Depends on swm_pkg, swm_cell and swm_ctrl.
//
// Samples enter a row of MAX_WINDOW cells, newest in cell 0, one cell per held sample.
// Once window_size samples of the current sequence have arrived, each new sample gives
// one word on the output: the largest of the newest window_size samples. A word with
// last_sample set is handled normally and then ends the sequence, emptying the window.
// A sample that gives no result leaves the block idle, ready for the next sample. After
// the shift of a sample that gives a result (window_size clamped to 1..MAX_WINDOW),
// a running maximum walks down the cell row one cell per clock, and the result is taken
// from cell window_size-1 into the output register. The input is stalled during that
// walk; the output register lets the next sample in while a result waits to be taken.
// window_size (reset 3; 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW) is
// written through the cfg port, which is always ready; write it only while idle.
// No clearing pass is needed after reset: cells are only read once written.
module sliding_window_maximum #(
  parameter int unsigned MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_window_size,
  // sample input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_window_max
);

  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  swm_pkg::swm_ctrl_t ctrl;
  logic [IW-1:0]      sel_idx;
  logic [IW:0]        sel_link;
  logic               out_free;

  logic signed [SAMPLE_BITS-1:0] s_link  [MAX_WINDOW+1];
  logic signed [SAMPLE_BITS-1:0] pm_link [MAX_WINDOW+1];

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_max_r;

  assign cfg_ready = 1'b1;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  swm_ctrl #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_window_size (cfg_window_size),
    .in_valid        (in_valid),
    .in_last_sample  (in_last_sample),
    .out_free        (out_free),
    .in_stall        (in_stall),
    .sel_idx         (sel_idx),
    .ctrl            (ctrl)
  );

  // cell 0 takes the new sample and starts the max wave from the most negative value
  assign s_link[0]  = in_sample;
  assign pm_link[0] = MOST_NEG;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk    (clk),
      .shift  (ctrl.shift),
      .s_in   (s_link[i]),
      .pm_in  (pm_link[i]),
      .s_out  (s_link[i+1]),
      .pm_out (pm_link[i+1])
    );
  end

  // cell k's running max sits on pm_link[k+1]
  assign sel_link = {1'b0, sel_idx} + (IW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.capture) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      out_max_r <= pm_link[sel_link];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;

endmodule

FILE: sim/sliding_window_maximum_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sliding_window_maximum: a directed table, then random phases.
// Depends on swm_pkg and the sliding_window_maximum RTL only.
module sliding_window_maximum_tb;

  localparam int unsigned SAMPLE_BITS     = swm_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned MAX_WINDOW      = swm_pkg::MAX_WINDOW_DEF;
  localparam int unsigned RANDOM_WORDS    = 1000;
  // time for the block to go quiet; scaled from MAX_WINDOW with margin
  localparam int unsigned SETTLE_CYCLES   = MAX_WINDOW + 4;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 500000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [swm_pkg::CFG_BITS-1:0]  cfg_word_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pick_t;

  // one row of the directed table; lit_en marks a result typed in by hand
  typedef struct packed {
    logic      cfg_en;
    cfg_word_t cfg_val;
    sample_t   smp;
    logic      last;
    logic      lit_en;
    sample_t   lit;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_word_t cfg_window_size;
  logic      in_valid;
  logic      in_stall;
  sample_t   in_sample;
  logic      in_last_sample;
  logic      out_valid;
  logic      out_stall;
  sample_t   out_window_max;

  sliding_window_maximum #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_window_size (cfg_window_size),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_max  (out_window_max)
  );

  // Directed table. Window starts at its reset size of 3.
  //   rows 0-5  : extremes of the sample range, ties at the most negative value
  //   row  6    : a sequence that ends before the window fills (no result)
  //   rows 7-8  : size 0 behaves as 1, then size 1
  //   rows 9-13 : size 4 partly filled, then shrunk to 2 in mid-sequence
  dir_row_t dir_plan [14] = '{
    '{1'b0, 5'd0, 16'sh8000,  1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0, 16'sh7FFF,  1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0, 16'sd0,     1'b0, 1'b1, 16'sh7FFF},
    '{1'b0, 5'd0, -16'sd1,    1'b0, 1'b1, 16'sh7FFF},
    '{1'b0, 5'd0, 16'sh8000,  1'b0, 1'b1, 16'sd0},
    '{1'b0, 5'd0, 16'sh8000,  1'b1, 1'b1, -16'sd1},
    '{1'b0, 5'd0, 16'sd5,     1'b1, 1'b0, 16'sd0},
    '{1'b1, 5'd0, 16'sh5555,  1'b0, 1'b1, 16'sh5555},
    '{1'b1, 5'd1, 16'shAAAA,  1'b1, 1'b1, 16'shAAAA},
    '{1'b1, 5'd4, 16'sd1,     1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0, 16'sd2,     1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0, 16'sd3,     1'b0, 1'b0, 16'sd0},
    '{1'b1, 5'd2, 16'sd7,     1'b0, 1'b1, 16'sd7},
    '{1'b0, 5'd0, -16'sd4,    1'b1, 1'b1, 16'sd7}
  };

  // corner window sizes for the first random phases; together they toggle every cfg bit
  cfg_word_t corner_sizes [5] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17};

  // window predictor state: newest sample in entry 0
  sample_t             held [MAX_WINDOW];
  int unsigned         held_count;
  cfg_word_t           win_size_q;
  sample_t             max_due [$];   // window maxima still owed by the block

  int unsigned         err_count    = 0;
  int unsigned         cycle_count  = 0;
  int unsigned         words_sent   = 0;
  int unsigned         burst_left   = 0;
  int unsigned         stall_tick   = 0;
  bit                  bursty       = 1'b1;
  bit                  hold_off_req = 1'b0;
  bit                  hold_off_done = 1'b0;
  stall_pick_t         stall_mode   = STALL_NONE;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit; a healthy run ends long before this
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch @%0d: %s", cycle_count, what);
    err_count++;
  endtask

  // size 0 acts as 1, anything past the cell row saturates
  function automatic int unsigned window_span(input cfg_word_t w);
    if (w == 0) return 1;
    if (w > MAX_WINDOW) return MAX_WINDOW;
    return w;
  endfunction

  // Offer one word, wait for it to be taken, then advance the predictor.
  // In bursty phases the sender runs in bursts; between bursts valid drops for a random gap.
  task automatic offer_word(input sample_t s, input logic l,
                            input logic use_lit, input sample_t lit);
    sample_t     peak;
    int unsigned span;
    if (burst_left == 0) begin
      if (bursty) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_sample <= l;
    do @(posedge clk); while (in_stall);
    words_sent++;

    for (int i = MAX_WINDOW - 1; i > 0; i--) held[i] = held[i-1];
    held[0] = s;
    if (held_count < MAX_WINDOW) held_count++;
    span = window_span(win_size_q);
    if (held_count >= span) begin
      peak = held[0];
      for (int i = 1; i < span; i++) if (held[i] > peak) peak = held[i];
      max_due.push_back(use_lit ? lit : peak);
    end
    if (l) held_count = 0;   // last word of a sequence empties the window
  endtask

  // Stop offering, wait for every owed maximum, then let the block go quiet.
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (max_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg port is only used while the block is idle
  task automatic write_window(input cfg_word_t v);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_window_size <= v;
    do @(posedge clk); while (!cfg_ready);
    win_size_q = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Receiver: stall pattern picked per phase, plus one long hold-off
  // so the output register fills and the input stalls behind it.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end else begin
        stall_tick++;
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ((stall_tick % 5) < 2);
        endcase
      end
    end
  end

  // Result checker: every word taken must match the oldest owed maximum.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (max_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %0d", out_window_max));
      end else if (out_window_max !== max_due[0]) begin
        flag_mismatch($sformatf("window_max got %0d want %0d",
                                out_window_max, max_due[0]));
        void'(max_due.pop_front());
      end else begin
        void'(max_due.pop_front());
      end
    end
  end

  initial begin
    int unsigned phase_words;
    int unsigned budget;
    int unsigned run_len;
    int unsigned span_now;
    cfg_word_t   size_pick;
    logic        last_now;
    bit          run_on;
    sample_t     s;

    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_window_size = '0;
    in_valid        = 1'b0;
    in_sample       = '0;
    in_last_sample  = 1'b0;
    held_count      = 0;
    win_size_q      = swm_pkg::WIN_SIZE_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed table, checked against typed values where given
    stall_mode = STALL_LIGHT;
    foreach (dir_plan[r]) begin
      if (dir_plan[r].cfg_en) begin
        settle();
        write_window(dir_plan[r].cfg_val);
      end
      offer_word(dir_plan[r].smp, dir_plan[r].last, dir_plan[r].lit_en, dir_plan[r].lit);
    end

    // Random phases. Each starts idle with a new window size; mostly small sizes
    // after the corners. Most runs are sequences closed by last_sample; some run on into
    // the next run or the next phase (size change mid-sequence), a few end early.
    words_sent = 0;
    for (int unsigned phase = 0; words_sent < RANDOM_WORDS; phase++) begin
      settle();
      if (phase < 5) size_pick = corner_sizes[phase];
      else if ($urandom_range(0, 3) != 0) size_pick = cfg_word_t'($urandom_range(1, 4));
      else size_pick = cfg_word_t'($urandom_range(0, 31));
      write_window(size_pick);
      stall_mode = stall_pick_t'($urandom_range(0, 3));
      bursty     = (phase % 3 != 1);
      if (phase == 3) hold_off_req = 1'b1;

      span_now    = window_span(size_pick);
      budget      = $urandom_range(40, 80);
      phase_words = 0;
      while (phase_words < budget) begin
        run_len = $urandom_range(1, 2 * span_now + 3);
        run_on  = ($urandom_range(0, 7) == 0);
        for (int unsigned k = 0; k < run_len; k++) begin
          case ($urandom_range(0, 7))
            0:       s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            1:       s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            2, 3:    s = sample_t'(int'($urandom_range(0, 6)) - 3);   // narrow range: ties
            default: s = sample_t'($urandom);
          endcase
          last_now = ((k == run_len - 1) && !run_on) || ($urandom_range(0, 15) == 0);
          offer_word(s, last_now, 1'b0, '0);
          phase_words++;
        end
      end
    end

    settle();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/swm_pkg.sv
design/swm_cell.sv
design/swm_ctrl.sv
design/sliding_window_maximum.sv
sim/sliding_window_maximum_tb.sv
